// ===== hw/rtl/kpg_pkg.sv =====
// ----------------------------------------------------------------------------
// kpg_pkg: shared types and constants of the Korobov lattice point generator
// Holds the command encodings, the queued command format and the back-end
// sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package kpg_pkg;

  localparam int FRAC_BITS    = 32;
  localparam int MAX_DIMS_DEF = 64;
  localparam int MOD_W        = 31;
  localparam int DIM_W        = 6;
  localparam int DIMS_W       = 7;
  localparam int CFG_W        = 2;

  localparam logic [MOD_W-1:0]  MODULUS_RST = MOD_W'(1024);
  localparam logic [DIMS_W-1:0] DIMS_RST    = DIMS_W'(1);

  typedef enum logic [1:0] {
    K_LOAD_GEN   = 2'd0,
    K_LOAD_SHIFT = 2'd1,
    K_EMIT       = 2'd2,
    K_RESTART    = 2'd3
  } kind_e;

  typedef enum logic [CFG_W-1:0] {
    CFG_MODULUS = 2'd0,
    CFG_DIMS    = 2'd1,
    CFG_SHIFT   = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_idx_e;

  // One classified item as it travels through the queue.
  typedef struct packed {
    kind_e                kind;
    logic [DIM_W-1:0]     dim;
    logic [FRAC_BITS-1:0] value;
    logic                 reject;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACK,
    S_RD,
    S_LAT,
    S_CHK,
    S_RED,
    S_FRAC,
    S_EMIT
  } back_state_e;

endpackage
`default_nettype wire

// ===== hw/rtl/kpg_front.sv =====
// ----------------------------------------------------------------------------
// kpg_front: command front end
// Accepts items and classifies them; a generator load that is not below the
// modulus is marked for rejection before it is queued.
// ----------------------------------------------------------------------------
`default_nettype none
module kpg_front (
  input  wire logic                          start_i,
  input  wire logic [1:0]                    kind_i,
  input  wire logic [kpg_pkg::DIM_W-1:0]     dim_select_i,
  input  wire logic [kpg_pkg::FRAC_BITS-1:0] load_value_i,
  input  wire logic [kpg_pkg::MOD_W-1:0]     modulus_i,
  input  wire logic                          full_i,
  output logic                               busy_o,
  output logic                               push_o,
  output kpg_pkg::cmd_t                      cmd_o
);

  // The queue being full is the only reason to hold items off.
  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  // Classify the item.
  always_comb begin
    cmd_o.kind   = kpg_pkg::kind_e'(kind_i);
    cmd_o.dim    = dim_select_i;
    cmd_o.value  = load_value_i;
    cmd_o.reject = (cmd_o.kind == kpg_pkg::K_LOAD_GEN) &&
                   (load_value_i >= {1'b0, modulus_i});
  end

endmodule
`default_nettype wire

// ===== hw/rtl/kpg_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// kpg_cmd_fifo: command queue
// A short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module kpg_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  kpg_pkg::cmd_t      cmd_i,
  input  wire logic          pop_i,
  output kpg_pkg::cmd_t      cmd_o,
  output logic               empty_o,
  output logic               full_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  kpg_pkg::cmd_t  mem_q [DEPTH];
  logic [AW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign cmd_o   = mem_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/kpg_back.sv =====
// ----------------------------------------------------------------------------
// kpg_back: command execution
// Holds the generator, shift and accumulator tables and walks the dimensions
// of an emit item through a bit-serial divider, one result per dimension.
// ----------------------------------------------------------------------------
`default_nettype none
module kpg_back #(
  parameter int MAX_DIMS = kpg_pkg::MAX_DIMS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [kpg_pkg::MOD_W-1:0]     modulus_i,
  input  wire logic [kpg_pkg::DIMS_W-1:0]    dims_i,
  input  wire logic                          shift_en_i,
  input  kpg_pkg::cmd_t                      cmd_i,
  input  wire logic                          empty_i,
  output logic                               pop_o,
  output logic                               valid_o,
  output logic [kpg_pkg::FRAC_BITS-1:0]      coordinate_o,
  output logic [kpg_pkg::DIM_W-1:0]          dim_out_o,
  output logic                               last_o,
  output logic                               status_o
);

  localparam int AW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int MW   = kpg_pkg::MOD_W;
  localparam int FB   = kpg_pkg::FRAC_BITS;
  localparam int DW   = kpg_pkg::DIM_W;
  localparam int NW   = kpg_pkg::DIMS_W;
  localparam int DLIM = (MAX_DIMS < 64) ? MAX_DIMS : 64;

  kpg_pkg::back_state_e state_q, state_d;
  kpg_pkg::cmd_t        cmd_q;

  logic [MW-1:0]  gen_mem [MAX_DIMS];
  logic [FB-1:0]  sh_mem  [MAX_DIMS];
  logic [MW-1:0]  acc_mem [MAX_DIMS];
  logic [MAX_DIMS-1:0] gen_vld_q, sh_vld_q, acc_vld_q;

  logic [MW-1:0] gen_rd_q, acc_rd_q;
  logic [FB-1:0] sh_rd_q;
  logic          gen_rv_q, sh_rv_q, acc_rv_q;

  logic [DW-1:0]  j_q;
  logic [NW-1:0]  d_q, d_eff;
  logic [MW-1:0]  a_q, g_q;
  logic [FB-1:0]  sh_q, q_q;
  logic [MW:0]    rem_q, rem_sh, rem_nx;
  logic [MW-1:0]  src_q;
  logic [5:0]     cnt_q;
  logic           red_g_q, frac_mode_q, ge;
  logic [MW:0]    acc_sum, acc_new;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic           dim_ok, is_last;

  // Control decodes.
  logic gen_we, sh_we, acc_we, acc_clr, out_ld;

  assign rd_addr = AW'(j_q);
  assign wr_addr = AW'(cmd_q.dim);
  assign dim_ok  = (32'(cmd_q.dim) < MAX_DIMS);
  assign is_last = ({1'b0, j_q} == d_q - 1'b1);

  // Dimensions per point after the zero and upper-limit corrections.
  always_comb begin
    d_eff = (dims_i == '0) ? NW'(1) : dims_i;
    if (d_eff > NW'(DLIM)) begin
      d_eff = NW'(DLIM);
    end
  end

  // One step of restoring division: shift in a bit, subtract if it fits.
  assign rem_sh = {rem_q[MW-1:0], frac_mode_q ? 1'b0 : src_q[MW-1]};
  assign ge     = (rem_sh >= {1'b0, modulus_i});
  assign rem_nx = ge ? rem_sh - {1'b0, modulus_i} : rem_sh;

  // Accumulator advance modulo n.
  assign acc_sum = {1'b0, a_q} + {1'b0, g_q};
  assign acc_new = (acc_sum >= {1'b0, modulus_i}) ? acc_sum - {1'b0, modulus_i} : acc_sum;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      kpg_pkg::S_IDLE: begin
        if (!empty_i) begin
          state_d = (cmd_i.kind == kpg_pkg::K_EMIT) ? kpg_pkg::S_RD : kpg_pkg::S_ACK;
        end
      end
      kpg_pkg::S_ACK:  state_d = kpg_pkg::S_IDLE;
      kpg_pkg::S_RD:   state_d = kpg_pkg::S_LAT;
      kpg_pkg::S_LAT:  state_d = kpg_pkg::S_CHK;
      kpg_pkg::S_CHK: begin
        state_d = (a_q >= modulus_i || g_q >= modulus_i) ? kpg_pkg::S_RED : kpg_pkg::S_FRAC;
      end
      kpg_pkg::S_RED:  if (cnt_q == '0) state_d = kpg_pkg::S_CHK;
      kpg_pkg::S_FRAC: if (cnt_q == '0) state_d = kpg_pkg::S_EMIT;
      kpg_pkg::S_EMIT: state_d = is_last ? kpg_pkg::S_IDLE : kpg_pkg::S_RD;
      default:         state_d = kpg_pkg::S_IDLE;
    endcase
  end

  // Output decodes.
  always_comb begin
    pop_o   = 1'b0;
    gen_we  = 1'b0;
    sh_we   = 1'b0;
    acc_we  = 1'b0;
    acc_clr = 1'b0;
    out_ld  = 1'b0;
    case (state_q)
      kpg_pkg::S_IDLE: pop_o = !empty_i;
      kpg_pkg::S_ACK: begin
        out_ld  = 1'b1;
        gen_we  = (cmd_q.kind == kpg_pkg::K_LOAD_GEN) && !cmd_q.reject && dim_ok;
        sh_we   = (cmd_q.kind == kpg_pkg::K_LOAD_SHIFT) && dim_ok;
        acc_clr = (cmd_q.kind == kpg_pkg::K_RESTART);
      end
      kpg_pkg::S_EMIT: begin
        out_ld = 1'b1;
        acc_we = 1'b1;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  // Sequencer state and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kpg_pkg::S_IDLE;
      valid_o   <= 1'b0;
      gen_vld_q <= '0;
      sh_vld_q  <= '0;
      acc_vld_q <= '0;
    end else begin
      state_q <= state_d;
      valid_o <= out_ld;
      if (gen_we) gen_vld_q[wr_addr] <= 1'b1;
      if (sh_we)  sh_vld_q[wr_addr]  <= 1'b1;
      if (acc_clr) begin
        acc_vld_q <= '0;
      end else if (acc_we) begin
        acc_vld_q[rd_addr] <= 1'b1;
      end
    end
  end

  // Table memories with registered reads.
  always_ff @(posedge clk_i) begin
    if (gen_we) gen_mem[wr_addr] <= cmd_q.value[MW-1:0];
    gen_rd_q <= gen_mem[rd_addr];
    gen_rv_q <= gen_vld_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sh_we) sh_mem[wr_addr] <= cmd_q.value;
    sh_rd_q <= sh_mem[rd_addr];
    sh_rv_q <= sh_vld_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[rd_addr] <= acc_new[MW-1:0];
    acc_rd_q <= acc_mem[rd_addr];
    acc_rv_q <= acc_vld_q[rd_addr];
  end

  // Datapath: operands, divider and result registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      kpg_pkg::S_IDLE: begin
        cmd_q <= cmd_i;
        j_q   <= '0;
        d_q   <= d_eff;
      end
      kpg_pkg::S_ACK: begin
        coordinate_o <= '0;
        dim_out_o    <= (cmd_q.kind == kpg_pkg::K_RESTART) ? '0 : cmd_q.dim;
        last_o       <= 1'b1;
        status_o     <= cmd_q.reject;
      end
      kpg_pkg::S_LAT: begin
        a_q  <= acc_rv_q ? acc_rd_q : '0;
        g_q  <= gen_rv_q ? gen_rd_q : '0;
        sh_q <= sh_rv_q ? sh_rd_q : '0;
      end
      kpg_pkg::S_CHK: begin
        // Reduce a stale accumulator first, then a stale generator.
        rem_q       <= (a_q >= modulus_i || g_q >= modulus_i) ? '0 : {1'b0, a_q};
        src_q       <= (a_q >= modulus_i) ? a_q : g_q;
        red_g_q     <= !(a_q >= modulus_i);
        frac_mode_q <= !(a_q >= modulus_i || g_q >= modulus_i);
        cnt_q       <= (a_q >= modulus_i || g_q >= modulus_i) ? 6'(MW - 1) : 6'(FB - 1);
        q_q         <= '0;
      end
      kpg_pkg::S_RED: begin
        rem_q <= rem_nx;
        src_q <= {src_q[MW-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (red_g_q) g_q <= rem_nx[MW-1:0];
          else         a_q <= rem_nx[MW-1:0];
        end
      end
      kpg_pkg::S_FRAC: begin
        rem_q <= rem_nx;
        q_q   <= {q_q[FB-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
      end
      kpg_pkg::S_EMIT: begin
        coordinate_o <= q_q + (shift_en_i ? sh_q : '0);
        dim_out_o    <= j_q;
        last_o       <= is_last;
        status_o     <= 1'b0;
        j_q          <= j_q + 1'b1;
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/korobov_lattice_point_generator.sv =====
// A load or restart item passes through the acknowledge state, which registers its single result.
// An emit item reads the tables for each dimension in use, first reduces any stale accumulator
// or generator, then runs the serial divider and emits the coordinate.
// The back end works on one item at a time; a two-entry queue takes items meanwhile.
// Reset clears configuration to defaults and marks every table entry as zero at once.
// Results are strobed for one cycle on valid_o; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// korobov_lattice_point_generator: rank-1 lattice point generator
// Emits frac(i*g_j/n) plus an optional shift for each dimension as 32-bit
// fractions; holds configuration registers and joins front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none
module korobov_lattice_point_generator #(
  parameter int MAX_DIMS = kpg_pkg::MAX_DIMS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    kind_i,
  input  wire logic [kpg_pkg::DIM_W-1:0]     dim_select_i,
  input  wire logic [kpg_pkg::FRAC_BITS-1:0] load_value_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [kpg_pkg::CFG_W-1:0]     cfg_index_i,
  input  wire logic [kpg_pkg::FRAC_BITS-1:0] cfg_data_i,
  output logic                               valid_o,
  output logic [kpg_pkg::FRAC_BITS-1:0]      coordinate_o,
  output logic [kpg_pkg::DIM_W-1:0]          dim_out_o,
  output logic                               last_o,
  output logic                               status_o
);

  logic [kpg_pkg::MOD_W-1:0]  modulus_q, modulus_eff;
  logic [kpg_pkg::DIMS_W-1:0] dims_q;
  logic                       shift_en_q;
  logic                       push, pop, empty, full;
  kpg_pkg::cmd_t              cmd_in, cmd_out;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= kpg_pkg::MODULUS_RST;
      dims_q     <= kpg_pkg::DIMS_RST;
      shift_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (kpg_pkg::cfg_idx_e'(cfg_index_i))
        kpg_pkg::CFG_MODULUS: modulus_q  <= cfg_data_i[kpg_pkg::MOD_W-1:0];
        kpg_pkg::CFG_DIMS:    dims_q     <= cfg_data_i[kpg_pkg::DIMS_W-1:0];
        kpg_pkg::CFG_SHIFT:   shift_en_q <= cfg_data_i[0];
        default:              shift_en_q <= shift_en_q;
      endcase
    end
  end

  // A zero modulus behaves as one.
  assign modulus_eff = (modulus_q == '0) ? kpg_pkg::MOD_W'(1) : modulus_q;

  kpg_front u_front (
    .start_i      (start),
    .kind_i       (kind_i),
    .dim_select_i (dim_select_i),
    .load_value_i (load_value_i),
    .modulus_i    (modulus_eff),
    .full_i       (full),
    .busy_o       (busy),
    .push_o       (push),
    .cmd_o        (cmd_in)
  );

  kpg_cmd_fifo #(
    .DEPTH (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .empty_o (empty),
    .full_o  (full)
  );

  kpg_back #(
    .MAX_DIMS (MAX_DIMS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .modulus_i    (modulus_eff),
    .dims_i       (dims_q),
    .shift_en_i   (shift_en_q),
    .cmd_i        (cmd_out),
    .empty_i      (empty),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .coordinate_o (coordinate_o),
    .dim_out_o    (dim_out_o),
    .last_o       (last_o),
    .status_o     (status_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/kpg_checker.sv =====
// ----------------------------------------------------------------------------
// kpg_checker: port-level checks for the lattice point generator
// Watches results over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module kpg_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          valid_o,
  input wire logic [kpg_pkg::FRAC_BITS-1:0] coordinate_o,
  input wire logic                          last_o,
  input wire logic                          status_o
);

  // A rejected load is a lone acknowledgment with a zero coordinate.
  a_reject_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o) |-> (last_o && coordinate_o == '0))
    else $error("rejection not on a zero last result");

  // Coordinates of one point are spaced by the divider; never adjacent.
  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> !valid_o)
    else $error("coordinates of one point in adjacent cycles");

  // A result is never shown in the first cycle after reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !valid_o)
    else $error("result right after reset");

  // Any result followed directly by another must have been a final one.
  a_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(valid_o)) |-> $past(last_o))
    else $error("result chain broken");

endmodule

bind korobov_lattice_point_generator kpg_checker u_kpg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_o      (valid_o),
  .coordinate_o (coordinate_o),
  .last_o       (last_o),
  .status_o     (status_o)
);
`default_nettype wire
